FILE: design/ipd_pkg.sv
// ----------------------------------------------------------------------------
// ipd_pkg - shared types and constants for the length-prefixed deframer
// Result codes, the queued result record, configuration record and the
// header text matched ahead of each frame.
// ----------------------------------------------------------------------------
`default_nettype none

package ipd_pkg;

   // request command codes
   localparam logic CMD_BYTE    = 1'b0;
   localparam logic CMD_TIMEOUT = 1'b1;

   // configuration register indexes
   localparam int  CSR_INDEX_BITS     = 1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DELIVER_LIMIT = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_LIMIT   = 1'b1;

   localparam logic [15:0] DELIVER_LIMIT_RESET = 16'd255;
   localparam logic [15:0] FRAME_LIMIT_RESET   = 16'd256;

   // "+IPD,"
   localparam int HEADER_LEN = 5;
   localparam int MATCH_BITS = 3;
   localparam logic [7:0] HEADER_TEXT [HEADER_LEN] = '{8'h2B, 8'h49, 8'h50, 8'h44, 8'h2C};

   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   // result queue between parser and output stage
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      OP_BYTE    = 2'd0,
      OP_DROP    = 2'd1,
      OP_TIMEOUT = 2'd2
   } op_kind_type;

   typedef struct packed {
      op_kind_type kind;
      logic [7:0]  data;
      logic        last;
      logic        trunc;
   } op_type;

   typedef struct packed {
      logic [15:0] deliver_limit;
      logic [15:0] frame_limit;
   } cfg_type;

endpackage : ipd_pkg

`default_nettype wire

FILE: design/ipd_front.sv
// ----------------------------------------------------------------------------
// ipd_front - header hunt, length parse and payload classification
// Takes one request per accept_i cycle; each yields at most one queued result.
// ----------------------------------------------------------------------------
`default_nettype none

module ipd_front #(
   parameter int LENGTH_CHARS = 9,
   parameter int COUNT_BITS   = 16
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire ipd_pkg::cfg_type cfg_i,
   input  wire logic            accept_i,
   input  wire logic            command_i,
   input  wire logic [7:0]      rx_byte_i,
   output      logic            res_valid_o,
   output      ipd_pkg::op_type res_o
);
   import ipd_pkg::*;

   localparam int LCW = $clog2(LENGTH_CHARS + 1);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   typedef enum logic [1:0] {
      PH_HUNT = 2'd0,
      PH_LEN  = 2'd1,
      PH_DATA = 2'd2
   } phase_type;

   phase_type               phase_ff,     phase_in;
   logic [MATCH_BITS-1:0]   match_ff,     match_in;
   logic [COUNT_BITS-1:0]   length_ff,    length_in;
   logic [LCW-1:0]          chars_ff,     chars_in;
   logic                    ended_ff,     ended_in;
   logic [COUNT_BITS-1:0]   left_ff,      left_in;
   logic [COUNT_BITS-1:0]   delivered_ff, delivered_in;

   logic [COUNT_BITS+3:0]   len_times10;
   logic [COUNT_BITS-1:0]   len_sat;
   logic                    is_digit;
   logic [COUNT_BITS-1:0]   left_dec;
   logic [COUNT_BITS-1:0]   deliv_inc;
   logic                    can_deliver;
   logic                    hit;
   logic [MATCH_BITS-1:0]   match_next;

   assign is_digit    = (rx_byte_i >= CHAR_ZERO) && (rx_byte_i <= CHAR_NINE);
   assign len_times10 = {1'b0, length_ff, 3'b000} + {3'b000, length_ff, 1'b0}
                      + (COUNT_BITS+4)'(rx_byte_i[3:0]);
   assign len_sat     = (len_times10[COUNT_BITS+3:COUNT_BITS] != 4'd0) ? COUNT_MAX
                      : len_times10[COUNT_BITS-1:0];
   assign left_dec    = left_ff - COUNT_BITS'(1);
   assign deliv_inc   = delivered_ff + COUNT_BITS'(1);
   assign can_deliver = 17'(delivered_ff) < 17'(cfg_i.deliver_limit);

   assign hit = (match_ff < MATCH_BITS'(HEADER_LEN)) && (rx_byte_i == HEADER_TEXT[match_ff]);
   always_comb begin
      if (hit) begin
         match_next = match_ff + MATCH_BITS'(1);
      end else if (rx_byte_i == HEADER_TEXT[0]) begin
         match_next = MATCH_BITS'(1);
      end else begin
         match_next = '0;
      end
   end

   always_comb begin
      phase_in     = phase_ff;
      match_in     = match_ff;
      length_in    = length_ff;
      chars_in     = chars_ff;
      ended_in     = ended_ff;
      left_in      = left_ff;
      delivered_in = delivered_ff;
      res_valid_o  = 1'b0;
      res_o        = '{kind: OP_BYTE, data: 8'h00, last: 1'b0, trunc: 1'b0};

      if (accept_i) begin
         if (command_i == CMD_TIMEOUT) begin
            if (phase_ff == PH_DATA && can_deliver) begin
               res_valid_o = 1'b1;
               res_o.kind  = OP_TIMEOUT;
               res_o.last  = 1'b1;
            end
            phase_in = PH_HUNT;
            match_in = '0;
         end else begin
            case (phase_ff)
               PH_LEN: begin
                  if (rx_byte_i == CHAR_COLON) begin
                     if (length_ff == '0) begin
                        phase_in = PH_HUNT;
                        match_in = '0;
                     end else if (17'(length_ff) >= 17'(cfg_i.frame_limit)) begin
                        phase_in    = PH_HUNT;
                        match_in    = '0;
                        res_valid_o = 1'b1;
                        res_o.kind  = OP_DROP;
                        res_o.last  = 1'b1;
                     end else begin
                        phase_in     = PH_DATA;
                        left_in      = length_ff;
                        delivered_in = '0;
                     end
                  end else if (chars_ff < LCW'(LENGTH_CHARS)) begin
                     chars_in = chars_ff + LCW'(1);
                     if (!ended_ff && is_digit) begin
                        length_in = len_sat;
                     end else begin
                        ended_in = 1'b1;
                     end
                  end
               end
               PH_DATA: begin
                  left_in = left_dec;
                  if (can_deliver) begin
                     delivered_in = deliv_inc;
                     res_valid_o  = 1'b1;
                     res_o.data   = rx_byte_i;
                     res_o.trunc  = (17'(deliv_inc) == 17'(cfg_i.deliver_limit))
                                 && (left_dec != '0);
                     res_o.last   = (left_dec == '0) || res_o.trunc;
                  end
                  if (left_dec == '0) begin
                     phase_in = PH_HUNT;
                     match_in = '0;
                  end
               end
               default: begin
                  // hunting; the spare phase code behaves the same
                  phase_in = PH_HUNT;
                  match_in = match_next;
                  if (match_next >= MATCH_BITS'(HEADER_LEN)) begin
                     phase_in  = PH_LEN;
                     match_in  = '0;
                     length_in = '0;
                     chars_in  = '0;
                     ended_in  = 1'b0;
                  end
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HUNT;
         match_ff     <= '0;
         length_ff    <= '0;
         chars_ff     <= '0;
         ended_ff     <= 1'b0;
         left_ff      <= '0;
         delivered_ff <= '0;
      end else begin
         phase_ff     <= phase_in;
         match_ff     <= match_in;
         length_ff    <= length_in;
         chars_ff     <= chars_in;
         ended_ff     <= ended_in;
         left_ff      <= left_in;
         delivered_ff <= delivered_in;
      end
   end

endmodule : ipd_front

`default_nettype wire

FILE: design/ipd_queue.sv
// ----------------------------------------------------------------------------
// ipd_queue - short result queue between parser and output stage
// Small register FIFO; lets the parser run while the output side stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module ipd_queue (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            push_i,
   input  wire ipd_pkg::op_type data_i,
   output      logic            full_o,
   input  wire logic            pop_i,
   output      logic            valid_o,
   output      ipd_pkg::op_type data_o
);
   import ipd_pkg::*;

   op_type                    entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0] count_ff,  count_in;
   logic                      do_push;
   logic                      do_pop;

   assign full_o  = (count_ff == QUEUE_CNT_BITS'(QUEUE_DEPTH));
   assign valid_o = (count_ff != '0);
   assign data_o  = entries_ff[rd_ptr_ff];
   assign do_push = push_i && !full_o;
   assign do_pop  = pop_i && valid_o;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (32'(wr_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_ff + QUEUE_PTR_BITS'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_ff + QUEUE_PTR_BITS'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + QUEUE_CNT_BITS'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QUEUE_CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= data_i;
      end
   end

   // the parser is held off while full, so no result is ever lost here
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      full_o |-> !push_i)
      else $error("result pushed into full queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_CNT_BITS'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

endmodule : ipd_queue

`default_nettype wire

FILE: design/ipd_back.sv
// ----------------------------------------------------------------------------
// ipd_back - output register stage
// Holds the oldest result on the response ports and refills from the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module ipd_back (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            q_valid_i,
   input  wire ipd_pkg::op_type q_data_i,
   output      logic            q_pop_o,
   output      logic            empty_o,
   input  wire logic            pop_i,
   output      logic [7:0]      payload_byte_o,
   output      logic [1:0]      status_o,
   output      logic            last_of_frame_o,
   output      logic            truncated_o
);
   import ipd_pkg::*;

   op_type out_ff;
   logic   valid_ff, valid_in;
   logic   taken;

   assign taken   = pop_i && valid_ff;
   assign q_pop_o = q_valid_i && (!valid_ff || taken);

   always_comb begin
      valid_in = valid_ff;
      if (q_pop_o) begin
         valid_in = 1'b1;
      end else if (taken) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop_o) begin
         out_ff <= q_data_i;
      end
   end

   assign empty_o         = !valid_ff;
   assign payload_byte_o  = (out_ff.kind == OP_BYTE) ? out_ff.data : 8'h00;
   assign status_o        = out_ff.kind;
   assign last_of_frame_o = out_ff.last;
   assign truncated_o     = out_ff.trunc;

   a_trunc_ends_frame: assert property (@(posedge clock) disable iff (reset)
      (!empty_o && truncated_o) |-> (last_of_frame_o && status_o == OP_BYTE))
      else $error("truncated result not marked last");

   a_status_ends_frame: assert property (@(posedge clock) disable iff (reset)
      (!empty_o && status_o != OP_BYTE) |-> (last_of_frame_o && !truncated_o
         && payload_byte_o == 8'h00))
      else $error("drop or timeout result malformed");

endmodule : ipd_back

`default_nettype wire

FILE: design/ipd_length_prefixed_deframer.sv
// ----------------------------------------------------------------------------
// ipd_length_prefixed_deframer - "+IPD,<len>:<payload>" stream deframer
// Parser, result queue and output register stage, plus the two limit CSRs.
// ----------------------------------------------------------------------------
// Takes one request (received byte or idle timeout) per clock and yields at
// most one response per request. Outside a frame it hunts for "+IPD,", reads
// the decimal length up to ':' and then passes payload bytes on, up to
// deliver_limit per frame; the rest are swallowed and the last passed byte is
// flagged truncated. Lengths at or above frame_limit give one drop response,
// a timeout mid-payload gives one incomplete response unless deliver_limit
// bytes were already passed. Each request is handled in the single cycle in
// which it is accepted, so the input runs at one byte per clock; full only
// rises when the two-entry result queue and the output register are all
// occupied, i.e. the result side has stalled. Responses go via the queue and
// the output register. Limits must be written through the csr channel while
// the block is idle; the block does not enforce it. csr_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module ipd_length_prefixed_deframer #(
   parameter int LENGTH_CHARS = 9,
   parameter int COUNT_BITS   = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // requests
   input  wire logic        push,
   output      logic        full,
   input  wire logic        req_command,
   input  wire logic [7:0]  req_rx_byte,
   // responses
   output      logic        empty,
   input  wire logic        pop,
   output      logic [7:0]  rsp_payload_byte,
   output      logic [1:0]  rsp_status,
   output      logic        rsp_last_of_frame,
   output      logic        rsp_truncated,
   // configuration
   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic [ipd_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [15:0] csr_wdata
);
   import ipd_pkg::*;

   logic [15:0] deliver_limit_ff;
   logic [15:0] frame_limit_ff;
   cfg_type     cfg;
   logic        accept;
   logic        res_valid;
   op_type      res;
   logic        q_full;
   logic        q_valid;
   op_type      q_data;
   logic        q_pop;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         deliver_limit_ff <= DELIVER_LIMIT_RESET;
         frame_limit_ff   <= FRAME_LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_DELIVER_LIMIT: deliver_limit_ff <= csr_wdata;
            CSR_FRAME_LIMIT:   frame_limit_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign cfg.deliver_limit = deliver_limit_ff;
   assign cfg.frame_limit   = frame_limit_ff;

   assign full   = q_full;
   assign accept = push && !full;

   ipd_front #(
      .LENGTH_CHARS (LENGTH_CHARS),
      .COUNT_BITS   (COUNT_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg_i       (cfg),
      .accept_i    (accept),
      .command_i   (req_command),
      .rx_byte_i   (req_rx_byte),
      .res_valid_o (res_valid),
      .res_o       (res)
   );

   ipd_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push_i  (res_valid),
      .data_i  (res),
      .full_o  (q_full),
      .pop_i   (q_pop),
      .valid_o (q_valid),
      .data_o  (q_data)
   );

   ipd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid_i       (q_valid),
      .q_data_i        (q_data),
      .q_pop_o         (q_pop),
      .empty_o         (empty),
      .pop_i           (pop),
      .payload_byte_o  (rsp_payload_byte),
      .status_o        (rsp_status),
      .last_of_frame_o (rsp_last_of_frame),
      .truncated_o     (rsp_truncated)
   );

endmodule : ipd_length_prefixed_deframer

`default_nettype wire
